### hdl/bpv_pkg.sv
// bpv_pkg: types, constants and helpers for the bone pyramid vertex generator.
// Used by bpv_norm, bpv_serial and bone_pyramid_vertex_generator; no dependencies.
`default_nettype none

package bpv_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam logic [32:0] MIN_LEN           = 33'd7;
	localparam logic [31:0] UP_LIMIT          = 32'd1063004406;
	localparam logic [34:0] MIN_WIDTH         = 35'd131;
	localparam logic [16:0] WIDTH_SCALE_RESET = 17'd3277;
	localparam logic [30:0] ONE_Q30           = 31'h4000_0000;

	localparam logic [2:0] CORNER_TIP  = 3'd0;
	localparam logic [2:0] CORNER_POSU = 3'd1;
	localparam logic [2:0] CORNER_POSV = 3'd2;
	localparam logic [2:0] CORNER_NEGU = 3'd3;
	localparam logic [2:0] CORNER_NEGV = 3'd4;

	typedef logic signed [31:0] coord_t;
	typedef coord_t [2:0] vec3_t;
	typedef logic [2:0][31:0] mag3_t;

	typedef struct packed {
		coord_t     parent_x;
		coord_t     parent_y;
		coord_t     parent_z;
		coord_t     child_x;
		coord_t     child_y;
		coord_t     child_z;
		logic [7:0] parent_bone;
	} in_item_t;

	typedef struct packed {
		logic [2:0] corner;
		coord_t     vert_x;
		coord_t     vert_y;
		coord_t     vert_z;
		logic [7:0] owner_bone;
		logic       last;
	} out_item_t;

	// Side data that rides along the normalize pipelines.
	typedef struct packed {
		vec3_t       p;
		vec3_t       c;
		logic [7:0]  bone;
		logic        sh;
		vec3_t       dir;
		vec3_t       u;
		logic [32:0] len;
		logic [34:0] wid;
		logic        keep;
	} ctx_t;

	// Five finished vertices of one bone.
	typedef struct packed {
		coord_t [4:0][2:0] v;
		logic [7:0]        bone;
		logic              keep;
	} pyr_t;

	function automatic coord_t sat32(input logic signed [37:0] x);
		coord_t r;
		if (x > 38'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (x < -38'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/bpv_norm.sv
// bpv_norm: pipelined 3-vector normalize to Q2.30 (squares, sum, bitwise sqrt,
// bitwise restoring divide). Depends on bpv_pkg.
`default_nettype none

module bpv_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  bpv_pkg::mag3_t  in_mag,
	input  logic [2:0]      in_neg,
	input  bpv_pkg::ctx_t   in_ctx,
	output logic            out_v,
	output bpv_pkg::vec3_t  out_unit,
	output logic [31:0]     out_len,
	output bpv_pkg::ctx_t   out_ctx
);
	import bpv_pkg::*;

	logic        v_s1, v_s2;
	logic [63:0] sq_s1 [3];
	logic [63:0] sum_s2;
	mag3_t       mag_s1, mag_s2;
	logic [2:0]  neg_s1, neg_s2;
	ctx_t        ctx_s1, ctx_s2;

	// sqrt stage registers
	logic        sv_s    [1:SQRT_STEPS];
	logic [63:0] sx_s    [1:SQRT_STEPS];
	logic [33:0] srem_s  [1:SQRT_STEPS];
	logic [31:0] sroot_s [1:SQRT_STEPS];
	mag3_t       smag_s  [1:SQRT_STEPS];
	logic [2:0]  sneg_s  [1:SQRT_STEPS];
	ctx_t        sctx_s  [1:SQRT_STEPS];

	// divide stage registers
	logic        dv_s   [1:DIV_STEPS];
	logic [32:0] dr_s   [1:DIV_STEPS][3];
	logic [30:0] dq_s   [1:DIV_STEPS][3];
	logic [31:0] dlen_s [1:DIV_STEPS];
	logic [2:0]  dneg_s [1:DIV_STEPS];
	ctx_t        dctx_s [1:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= in_mag[k] * in_mag[k];
			end
			mag_s1 <= in_mag;
			neg_s1 <= in_neg;
			ctx_s1 <= in_ctx;
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			ctx_s2 <= ctx_s1;
		end
	end

	// floor sqrt, two radicand bits per stage
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic        v_i;
		logic [63:0] x_i;
		logic [33:0] rem_i;
		logic [31:0] root_i;
		mag3_t       mag_i;
		logic [2:0]  neg_i;
		ctx_t        ctx_i;
		logic [34:0] acc;
		logic [34:0] trial;
		logic        ge;

		if (j == 0) begin : g_src
			assign v_i    = v_s2;
			assign x_i    = sum_s2;
			assign rem_i  = '0;
			assign root_i = '0;
			assign mag_i  = mag_s2;
			assign neg_i  = neg_s2;
			assign ctx_i  = ctx_s2;
		end else begin : g_src
			assign v_i    = sv_s[j];
			assign x_i    = sx_s[j];
			assign rem_i  = srem_s[j];
			assign root_i = sroot_s[j];
			assign mag_i  = smag_s[j];
			assign neg_i  = sneg_s[j];
			assign ctx_i  = sctx_s[j];
		end

		assign acc   = {rem_i[32:0], x_i[63:62]};
		assign trial = {1'b0, root_i, 2'b01};
		assign ge    = (acc >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[j+1] <= 1'b0;
			end else if (adv) begin
				sv_s[j+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sx_s[j+1]    <= {x_i[61:0], 2'b00};
				srem_s[j+1]  <= ge ? 34'(acc - trial) : acc[33:0];
				sroot_s[j+1] <= {root_i[30:0], ge};
				smag_s[j+1]  <= mag_i;
				sneg_s[j+1]  <= neg_i;
				sctx_s[j+1]  <= ctx_i;
			end
		end
	end

	// mag * 2^30 / len, one quotient bit per stage; first bit is the integer bit
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic        v_i;
		logic [32:0] rin [3];
		logic [30:0] q_i [3];
		logic [31:0] len_i;
		logic [2:0]  neg_i;
		ctx_t        ctx_i;

		if (j == 0) begin : g_src
			assign v_i   = sv_s[SQRT_STEPS];
			assign len_i = sroot_s[SQRT_STEPS];
			assign neg_i = sneg_s[SQRT_STEPS];
			assign ctx_i = sctx_s[SQRT_STEPS];
			for (genvar k = 0; k < 3; k++) begin : g_k
				assign rin[k] = {1'b0, smag_s[SQRT_STEPS][k]};
				assign q_i[k] = '0;
			end
		end else begin : g_src
			assign v_i   = dv_s[j];
			assign len_i = dlen_s[j];
			assign neg_i = dneg_s[j];
			assign ctx_i = dctx_s[j];
			for (genvar k = 0; k < 3; k++) begin : g_k
				assign rin[k] = {dr_s[j][k][31:0], 1'b0};
				assign q_i[k] = dq_s[j][k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_s[j+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < 3; k++) begin
					if (rin[k] >= {1'b0, len_i}) begin
						dr_s[j+1][k] <= rin[k] - {1'b0, len_i};
						dq_s[j+1][k] <= {q_i[k][29:0], 1'b1};
					end else begin
						dr_s[j+1][k] <= rin[k];
						dq_s[j+1][k] <= {q_i[k][29:0], 1'b0};
					end
				end
				dlen_s[j+1] <= len_i;
				dneg_s[j+1] <= neg_i;
				dctx_s[j+1] <= ctx_i;
			end
		end
	end

	always_comb begin
		logic [30:0] qc;
		for (int k = 0; k < 3; k++) begin
			qc = dq_s[DIV_STEPS][k];
			if (dlen_s[DIV_STEPS] == '0) begin
				qc = '0;
			end else if (qc > ONE_Q30) begin
				qc = ONE_Q30;
			end
			out_unit[k] = dneg_s[DIV_STEPS][k] ? -{1'b0, qc} : {1'b0, qc};
		end
	end

	assign out_v   = dv_s[DIV_STEPS];
	assign out_len = dlen_s[DIV_STEPS];
	assign out_ctx = dctx_s[DIV_STEPS];

endmodule

`default_nettype wire

### hdl/bpv_serial.sv
// bpv_serial: output stage; holds one bone's five vertices and sends them
// one transfer per cycle while out_ready is high. Depends on bpv_pkg.
`default_nettype none

module bpv_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_v,
	input  bpv_pkg::pyr_t       in_pyr,
	output logic                in_rdy,
	output logic                out_valid,
	input  logic                out_ready,
	output bpv_pkg::out_item_t  out_data
);
	import bpv_pkg::*;

	logic       full_q;
	logic [2:0] cnt_q;
	pyr_t       pyr_q;
	logic       done;
	logic       take;
	logic [2:0] sel;

	assign done   = full_q && out_ready && (cnt_q == CORNER_NEGV);
	assign in_rdy = !full_q || done;
	assign take   = in_v && in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q  <= CORNER_TIP;
		end else if (take) begin
			full_q <= in_pyr.keep;
			cnt_q  <= CORNER_TIP;
		end else if (done) begin
			full_q <= 1'b0;
			cnt_q  <= CORNER_TIP;
		end else if (full_q && out_ready) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pyr_q <= in_pyr;
		end
	end

	always_comb begin
		case (cnt_q)
			CORNER_TIP:  sel = 3'd0;
			CORNER_POSU: sel = 3'd1;
			CORNER_POSV: sel = 3'd2;
			CORNER_NEGU: sel = 3'd3;
			default:     sel = 3'd4;
		endcase
		out_data.corner     = cnt_q;
		out_data.vert_x     = pyr_q.v[sel][0];
		out_data.vert_y     = pyr_q.v[sel][1];
		out_data.vert_z     = pyr_q.v[sel][2];
		out_data.owner_bone = pyr_q.bone;
		out_data.last       = (cnt_q == CORNER_NEGV);
	end

	assign out_valid = full_q;

`ifndef NO_ASSERTIONS
	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q <= CORNER_NEGV))
		else $error("corner counter out of range");

	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_data.last)
		|=> (out_valid && out_data.corner == $past(out_data.corner) + 3'd1))
		else $error("vertex sequence broken inside a pyramid");

	a_new_at_tip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last && out_valid) |=>
		(!out_valid || out_data.corner == CORNER_TIP))
		else $error("new pyramid does not start at the tip");
`endif

endmodule

`default_nettype wire

### hdl/bone_pyramid_vertex_generator.sv
// bone_pyramid_vertex_generator: top level; front end, basis and offset stages,
// three bpv_norm pipelines and the bpv_serial output stage. Depends on bpv_pkg.
`default_nettype none

// One bone (parent P, child C, signed Q16.16) goes in per input transfer and,
// unless it is shorter than 7 LSB, five vertices come out: tip at C, then
// P+U*w, P+V*w, P-U*w, P-V*w, the last one flagged. Short bones produce no
// output at all. The datapath is a stall-as-a-whole pipeline of 203 stages
// (difference, magnitude, three normalize units of 65 stages each: squares,
// sum, 32-step square root, 31-step divide; then basis, cross product, width,
// offset multiply, offset sum and vertex add) followed by a one-bone output
// buffer. The pipeline takes a new bone every cycle while it has room;
// sustained, the output port sets the pace, sending one vertex per transfer.
// Coordinates that fall outside the 32-bit range saturate. width_scale is
// written through cfg_we/cfg_wdata and should only change while the block is
// empty.
module bone_pyramid_vertex_generator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [16:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpv_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bpv_pkg::out_item_t  out_data
);
	import bpv_pkg::*;

	logic [16:0] ws_q;
	logic        adv;
	logic        ser_rdy;

	// front end
	logic               v_s1, v_s2;
	vec3_t              p_s1, c_s1;
	logic [7:0]         bone_s1;
	logic signed [32:0] d_s1 [3];
	mag3_t              m_s2;
	logic [2:0]         neg_s2;
	ctx_t               ctx_s2;

	// normalize A: bone direction
	logic  va;
	vec3_t unit_a;
	logic [31:0] len_a;
	ctx_t  ctx_a;

	logic  v_s3;
	mag3_t m_s3;
	logic [2:0] neg_s3;
	ctx_t  ctx_s3;

	// normalize B: U
	logic  vb;
	vec3_t unit_b;
	logic [31:0] len_b;
	ctx_t  ctx_b;

	logic               v_s4;
	logic signed [63:0] pr_s4 [6];
	logic [49:0]        wp_s4;
	ctx_t               ctx_s4;

	logic       v_s5;
	mag3_t      m_s5;
	logic [2:0] neg_s5;
	ctx_t       ctx_s5;

	// normalize C: V
	logic  vc;
	vec3_t unit_c;
	logic [31:0] len_c;
	ctx_t  ctx_c;

	logic        v_s6;
	logic [49:0] hiu_s6 [3], hiv_s6 [3];
	logic [46:0] lou_s6 [3], lov_s6 [3];
	logic [2:0]  nu_s6, nv_s6;
	ctx_t        ctx_s6;

	logic        v_s7;
	logic [36:0] offu_s7 [3], offv_s7 [3];
	logic [2:0]  nu_s7, nv_s7;
	ctx_t        ctx_s7;

	logic v_s8;
	pyr_t pyr_s8;

	// whole pipeline moves together; it only holds when the output stage is
	// busy and the last stage has a bone waiting
	assign adv      = !v_s8 || ser_rdy;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WIDTH_SCALE_RESET;
		end else if (cfg_we) begin
			ws_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= va;
			v_s4 <= vb;
			v_s5 <= v_s4;
			v_s6 <= vc;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// s1: exact 33-bit differences C - P
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= {in_data.parent_z, in_data.parent_y, in_data.parent_x};
			c_s1    <= {in_data.child_z, in_data.child_y, in_data.child_x};
			bone_s1 <= in_data.parent_bone;
			d_s1[0] <= $signed({in_data.child_x[31], in_data.child_x})
				- $signed({in_data.parent_x[31], in_data.parent_x});
			d_s1[1] <= $signed({in_data.child_y[31], in_data.child_y})
				- $signed({in_data.parent_y[31], in_data.parent_y});
			d_s1[2] <= $signed({in_data.child_z[31], in_data.child_z})
				- $signed({in_data.parent_z[31], in_data.parent_z});
		end
	end

	// s2: magnitudes; halve all three if any reaches 2^31
	logic [32:0] dm [3];
	logic        big;
	ctx_t        ctx_n2;
	always_comb begin
		big = 1'b0;
		for (int k = 0; k < 3; k++) begin
			dm[k] = d_s1[k][32] ? 33'(-d_s1[k]) : d_s1[k];
			big   = big | dm[k][32] | dm[k][31];
		end
		ctx_n2      = '0;
		ctx_n2.p    = p_s1;
		ctx_n2.c    = c_s1;
		ctx_n2.bone = bone_s1;
		ctx_n2.sh   = big;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				m_s2[k]   <= big ? dm[k][32:1] : dm[k][31:0];
				neg_s2[k] <= d_s1[k][32];
			end
			ctx_s2 <= ctx_n2;
		end
	end

	bpv_norm u_norm_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s2),
		.in_mag   (m_s2),
		.in_neg   (neg_s2),
		.in_ctx   (ctx_s2),
		.out_v    (va),
		.out_unit (unit_a),
		.out_len  (len_a),
		.out_ctx  (ctx_a)
	);

	// s3: length, short-bone flag, pick up axis and form up x dir
	logic [32:0] len_full;
	logic [31:0] dmag [3];
	logic        up_z;
	ctx_t        ctx_n3;
	always_comb begin
		len_full = ctx_a.sh ? {len_a, 1'b0} : {1'b0, len_a};
		for (int k = 0; k < 3; k++) begin
			dmag[k] = unit_a[k][31] ? 32'(-unit_a[k]) : unit_a[k];
		end
		up_z = (dmag[2] < UP_LIMIT);
		ctx_n3      = ctx_a;
		ctx_n3.dir  = unit_a;
		ctx_n3.len  = len_full;
		ctx_n3.keep = (len_full >= MIN_LEN);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (up_z) begin
				m_s3   <= {32'd0, dmag[0], dmag[1]};
				neg_s3 <= {1'b0, unit_a[0][31], !unit_a[1][31]};
			end else begin
				m_s3   <= {dmag[0], 32'd0, dmag[2]};
				neg_s3 <= {!unit_a[0][31], 1'b0, unit_a[2][31]};
			end
			ctx_s3 <= ctx_n3;
		end
	end

	bpv_norm u_norm_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s3),
		.in_mag   (m_s3),
		.in_neg   (neg_s3),
		.in_ctx   (ctx_s3),
		.out_v    (vb),
		.out_unit (unit_b),
		.out_len  (len_b),
		.out_ctx  (ctx_b)
	);

	// s4: cross product terms and raw width product
	ctx_t ctx_n4;
	always_comb begin
		ctx_n4   = ctx_b;
		ctx_n4.u = unit_b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s4[0] <= $signed(ctx_b.dir[1]) * $signed(unit_b[2]);
			pr_s4[1] <= $signed(ctx_b.dir[2]) * $signed(unit_b[1]);
			pr_s4[2] <= $signed(ctx_b.dir[2]) * $signed(unit_b[0]);
			pr_s4[3] <= $signed(ctx_b.dir[0]) * $signed(unit_b[2]);
			pr_s4[4] <= $signed(ctx_b.dir[0]) * $signed(unit_b[1]);
			pr_s4[5] <= $signed(ctx_b.dir[1]) * $signed(unit_b[0]);
			wp_s4    <= ctx_b.len * ws_q;
			ctx_s4   <= ctx_n4;
		end
	end

	// s5: dir x U truncated toward zero to Q2.30; width with floor
	logic signed [63:0] td [3];
	logic [63:0]        tm [3];
	logic [33:0]        wq;
	ctx_t               ctx_n5;
	always_comb begin
		td[0] = pr_s4[0] - pr_s4[1];
		td[1] = pr_s4[2] - pr_s4[3];
		td[2] = pr_s4[4] - pr_s4[5];
		for (int k = 0; k < 3; k++) begin
			tm[k] = td[k][63] ? 64'(-td[k]) : td[k];
		end
		wq = wp_s4[49:16];
		ctx_n5     = ctx_s4;
		ctx_n5.wid = ({1'b0, wq} < MIN_WIDTH) ? MIN_WIDTH : {1'b0, wq};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				m_s5[k]   <= tm[k][61:30];
				neg_s5[k] <= td[k][63];
			end
			ctx_s5 <= ctx_n5;
		end
	end

	bpv_norm u_norm_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s5),
		.in_mag   (m_s5),
		.in_neg   (neg_s5),
		.in_ctx   (ctx_s5),
		.out_v    (vc),
		.out_unit (unit_c),
		.out_len  (len_c),
		.out_ctx  (ctx_c)
	);

	// s6: |U_i| * w and |V_i| * w as high and low partial products
	logic [30:0] um [3], vm [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			um[k] = ctx_c.u[k][31] ? 31'(-ctx_c.u[k]) : ctx_c.u[k][30:0];
			vm[k] = unit_c[k][31] ? 31'(-unit_c[k]) : unit_c[k][30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				hiu_s6[k] <= um[k] * ctx_c.wid[34:16];
				lou_s6[k] <= um[k] * ctx_c.wid[15:0];
				hiv_s6[k] <= vm[k] * ctx_c.wid[34:16];
				lov_s6[k] <= vm[k] * ctx_c.wid[15:0];
				nu_s6[k]  <= ctx_c.u[k][31];
				nv_s6[k]  <= unit_c[k][31];
			end
			ctx_s6 <= ctx_c;
		end
	end

	// s7: floor(|b| * w / 2^30), exact
	logic [47:0] lsu [3], lsv [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lsu[k] = {18'd0, hiu_s6[k][13:0], 16'd0} + {1'b0, lou_s6[k]};
			lsv[k] = {18'd0, hiv_s6[k][13:0], 16'd0} + {1'b0, lov_s6[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				offu_s7[k] <= {1'b0, hiu_s6[k][49:14]} + {19'd0, lsu[k][47:30]};
				offv_s7[k] <= {1'b0, hiv_s6[k][49:14]} + {19'd0, lsv[k][47:30]};
			end
			nu_s7  <= nu_s6;
			nv_s7  <= nv_s6;
			ctx_s7 <= ctx_s6;
		end
	end

	// s8: P +/- offsets with saturation
	logic signed [37:0] pe [3];
	logic signed [37:0] upp [3], upm [3], vpp [3], vpm [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pe[k]  = {{6{ctx_s7.p[k][31]}}, ctx_s7.p[k]};
			upp[k] = pe[k] + $signed({1'b0, offu_s7[k]});
			upm[k] = pe[k] - $signed({1'b0, offu_s7[k]});
			vpp[k] = pe[k] + $signed({1'b0, offv_s7[k]});
			vpm[k] = pe[k] - $signed({1'b0, offv_s7[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pyr_s8.v[0][k] <= ctx_s7.c[k];
				pyr_s8.v[1][k] <= sat32(nu_s7[k] ? upm[k] : upp[k]);
				pyr_s8.v[2][k] <= sat32(nv_s7[k] ? vpm[k] : vpp[k]);
				pyr_s8.v[3][k] <= sat32(nu_s7[k] ? upp[k] : upm[k]);
				pyr_s8.v[4][k] <= sat32(nv_s7[k] ? vpp[k] : vpm[k]);
			end
			pyr_s8.bone <= ctx_s7.bone;
			pyr_s8.keep <= ctx_s7.keep;
		end
	end

	bpv_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_v      (v_s8),
		.in_pyr    (pyr_s8),
		.in_rdy    (ser_rdy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
